@@ rtl/core/hohni_pkg.sv @@
// Shared types, constants and helpers of the high-order hex node index block.
package hohni_pkg;

  localparam int unsigned OrdW   = 4;
  localparam int unsigned CrdW   = 4;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned ClsW   = 2;
  localparam int unsigned MulBW  = 4;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [IdxW-1:0] CornerCount = IdxW'(8);

  // Node classes
  localparam logic [ClsW-1:0] ClsVertex = 2'd0;
  localparam logic [ClsW-1:0] ClsEdge   = 2'd1;
  localparam logic [ClsW-1:0] ClsFace   = 2'd2;
  localparam logic [ClsW-1:0] ClsBody   = 2'd3;

  // Register word indexes (byte address / 4)
  localparam logic [1:0] RegOrderI = 2'd0;
  localparam logic [1:0] RegOrderJ = 2'd1;
  localparam logic [1:0] RegOrderK = 2'd2;

  // Classified transaction: index = add + mul1_a*mul1_b + mul2_a*mul2_b (mod 4096)
  typedef struct packed {
    logic [IdxW-1:0]  add;
    logic [IdxW-1:0]  mul1_a;
    logic [MulBW-1:0] mul1_b;
    logic [IdxW-1:0]  mul2_a;
    logic [MulBW-1:0] mul2_b;
    logic [ClsW-1:0]  cls;
    logic             oor;
  } entry_t;

  // Axis orders as seen by the front end
  typedef struct packed {
    logic [OrdW-1:0] ord_i;
    logic [OrdW-1:0] ord_j;
    logic [OrdW-1:0] ord_k;
  } orders_t;

  // Corner number within a k-layer, from which ends of i and j
  function automatic logic [1:0] corner_quad(input logic i_hi, input logic j_hi);
    logic [1:0] q;
    case ({i_hi, j_hi})
      2'b00:   q = 2'd0;
      2'b10:   q = 2'd1;
      2'b11:   q = 2'd2;
      2'b01:   q = 2'd3;
      default: q = 2'd0;
    endcase
    return q;
  endfunction

endpackage

@@ rtl/core/hohni_front.sv @@
// Front end: classify a coordinate triple and build its index operands.
module hohni_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hohni_pkg::orders_t               orders_i,
  input  logic [hohni_pkg::CrdW-1:0]       coord_i_i,
  input  logic [hohni_pkg::CrdW-1:0]       coord_j_i,
  input  logic [hohni_pkg::CrdW-1:0]       coord_k_i,
  output hohni_pkg::entry_t                entry_o
);

  localparam int unsigned W = hohni_pkg::IdxW;

  logic [W-1:0] om_i, om_j, om_k;
  logic [W-1:0] oi, oj, ok;
  logic [W-1:0] fi_q, fj_q, fk_q;
  logic [W-1:0] fi_d, fj_d, fk_d;
  logic [W-1:0] base_ek_q, base_face_q, base_fj_q, base_fk_q, base_body_q;
  logic [W-1:0] base_ek_d, base_face_d, base_fj_d, base_fk_d, base_body_d;

  // Order-derived terms, all modulo 4096
  assign oi   = W'(orders_i.ord_i);
  assign oj   = W'(orders_i.ord_j);
  assign ok   = W'(orders_i.ord_k);
  assign om_i = oi - W'(1);
  assign om_j = oj - W'(1);
  assign om_k = ok - W'(1);

  assign fi_d = W'(om_j * om_k);
  assign fj_d = W'(om_k * om_i);
  assign fk_d = W'(om_i * om_j);

  assign base_ek_d   = hohni_pkg::CornerCount + W'(om_i << 2) + W'(om_j << 2);
  assign base_face_d = hohni_pkg::CornerCount + W'((oi + oj + ok - W'(3)) << 2);
  assign base_fj_d   = base_face_q + W'(fi_q << 1);
  assign base_fk_d   = base_fj_q + W'(fj_q << 1);
  assign base_body_d = base_fk_q + W'(fk_q << 1);

  // Track the order registers; the bases chain face, fj, fk, then body
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fi_q        <= '0;
      fj_q        <= '0;
      fk_q        <= '0;
      base_ek_q   <= hohni_pkg::CornerCount;
      base_face_q <= hohni_pkg::CornerCount;
      base_fj_q   <= hohni_pkg::CornerCount;
      base_fk_q   <= hohni_pkg::CornerCount;
      base_body_q <= hohni_pkg::CornerCount;
    end else begin
      fi_q        <= fi_d;
      fj_q        <= fj_d;
      fk_q        <= fk_d;
      base_ek_q   <= base_ek_d;
      base_face_q <= base_face_d;
      base_fj_q   <= base_fj_d;
      base_fk_q   <= base_fk_d;
      base_body_q <= base_body_d;
    end
  end

  logic          oor;
  logic          ib, jb, kb;
  logic          i_hi, j_hi, k_hi;
  logic [1:0]    nb;
  logic [1:0]    quad;
  logic [W-1:0]  im1, jm1, km1, ring;

  assign oor  = (coord_i_i > orders_i.ord_i) || (coord_j_i > orders_i.ord_j) ||
                (coord_k_i > orders_i.ord_k);
  assign i_hi = (coord_i_i != '0);
  assign j_hi = (coord_j_i != '0);
  assign k_hi = (coord_k_i != '0);
  assign ib   = !i_hi || (coord_i_i == orders_i.ord_i);
  assign jb   = !j_hi || (coord_j_i == orders_i.ord_j);
  assign kb   = !k_hi || (coord_k_i == orders_i.ord_k);
  assign nb   = 2'(ib) + 2'(jb) + 2'(kb);
  assign quad = hohni_pkg::corner_quad(i_hi, j_hi);
  assign im1  = W'(coord_i_i) - W'(1);
  assign jm1  = W'(coord_j_i) - W'(1);
  assign km1  = W'(coord_k_i) - W'(1);
  assign ring = W'((oi + oj - W'(2)) << 1);

  // Select class and operands
  always_comb begin
    entry_o = '0;
    entry_o.oor = oor;
    if (!oor) begin
      case (nb)
        2'd3: begin
          entry_o.cls = hohni_pkg::ClsVertex;
          entry_o.add = W'(quad) + (k_hi ? W'(4) : W'(0));
        end
        2'd2: begin
          entry_o.cls = hohni_pkg::ClsEdge;
          if (!ib) begin
            entry_o.add = im1 + (j_hi ? (oi + oj - W'(2)) : W'(0)) +
                          (k_hi ? ring : W'(0)) + hohni_pkg::CornerCount;
          end else if (!jb) begin
            entry_o.add = jm1 + (i_hi ? om_i : (W'(om_i << 1) + om_j)) +
                          (k_hi ? ring : W'(0)) + hohni_pkg::CornerCount;
          end else begin
            entry_o.add    = km1 + base_ek_q;
            entry_o.mul1_a = om_k;
            entry_o.mul1_b = hohni_pkg::MulBW'(quad);
          end
        end
        2'd1: begin
          entry_o.cls = hohni_pkg::ClsFace;
          if (ib) begin
            entry_o.add    = jm1 + (i_hi ? fi_q : W'(0)) + base_face_q;
            entry_o.mul1_a = om_j;
            entry_o.mul1_b = km1[hohni_pkg::MulBW-1:0];
          end else if (jb) begin
            entry_o.add    = im1 + (j_hi ? fj_q : W'(0)) + base_fj_q;
            entry_o.mul1_a = om_i;
            entry_o.mul1_b = km1[hohni_pkg::MulBW-1:0];
          end else begin
            entry_o.add    = im1 + (k_hi ? fk_q : W'(0)) + base_fk_q;
            entry_o.mul1_a = om_i;
            entry_o.mul1_b = jm1[hohni_pkg::MulBW-1:0];
          end
        end
        default: begin
          entry_o.cls    = hohni_pkg::ClsBody;
          entry_o.add    = im1 + base_body_q;
          entry_o.mul1_a = om_i;
          entry_o.mul1_b = jm1[hohni_pkg::MulBW-1:0];
          entry_o.mul2_a = fk_q;
          entry_o.mul2_b = km1[hohni_pkg::MulBW-1:0];
        end
      endcase
    end
  end

endmodule

@@ rtl/core/hohni_queue.sv @@
// Two-entry queue between the classifying front end and the index back end.
module hohni_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hohni_pkg::entry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output hohni_pkg::entry_t pop_data_o
);

  hohni_pkg::entry_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed transaction
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/core/hohni_back.sv @@
// Back end: multiply-accumulate the operands into the index and hold the result.
module hohni_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              empty_i,
  input  hohni_pkg::entry_t                 entry_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [hohni_pkg::IdxW-1:0]        node_index_o,
  output logic [hohni_pkg::ClsW-1:0]        node_class_o,
  output logic                              out_of_range_o
);

  localparam int unsigned W = hohni_pkg::IdxW;

  logic         valid_q;
  logic [W-1:0] index_q, index_d;
  logic [hohni_pkg::ClsW-1:0] cls_q;
  logic         oor_q;

  // Take the next transaction when the output register is free or draining
  assign pop_o = !empty_i && (!valid_q || !out_stall_i);

  assign index_d = entry_i.add + W'(entry_i.mul1_a * W'(entry_i.mul1_b)) +
                   W'(entry_i.mul2_a * W'(entry_i.mul2_b));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      index_q <= index_d;
      cls_q   <= entry_i.cls;
      oor_q   <= entry_i.oor;
    end
  end

  assign out_valid_o    = valid_q;
  assign node_index_o   = index_q;
  assign node_class_o   = cls_q;
  assign out_of_range_o = oor_q;

endmodule

@@ rtl/core/high_order_hex_node_index.sv @@
// Top level of the high-order hexahedron node index block.
// Maps a lattice coordinate (coord_i, coord_j, coord_k) of a high-order hex
// element to its linear node index: corners, then edges, faces and interior.
// Input channel: in_valid_i / in_stall_o with the three coordinates; a
// transaction moves on an edge where valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i with node_index_o, node_class_o
// (vertex, edge, face, body) and out_of_range_o, which comes with index 0.
// Coordinates pass through the queue and then the output register; one
// coordinate per cycle is sustained while out_stall_i stays low, set by the
// combinational classify stage and the registered multiply-add stage,
// joined by a two-entry queue. The APB port holds order_i, order_j, order_k at byte addresses 0, 4, 8;
// write them only while idle, and allow four cycles before the next input
// while the derived face sizes and offsets settle.
// Reset sets all orders to 1 and empties the queue and output register.
// While the receiver stalls, the output holds; the queue absorbs up to two
// more coordinates and then in_stall_o rises.
module high_order_hex_node_index (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [hohni_pkg::CrdW-1:0]         coord_i_i,
  input  logic [hohni_pkg::CrdW-1:0]         coord_j_i,
  input  logic [hohni_pkg::CrdW-1:0]         coord_k_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [hohni_pkg::IdxW-1:0]         node_index_o,
  output logic [hohni_pkg::ClsW-1:0]         node_class_o,
  output logic                               out_of_range_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hohni_pkg::AddrW-1:0]        paddr,
  input  logic [hohni_pkg::DataW-1:0]        pwdata,
  output logic [hohni_pkg::DataW-1:0]        prdata,
  output logic                               pready
);

  hohni_pkg::orders_t orders_q;
  hohni_pkg::entry_t  front_entry, queue_entry;
  logic               cfg_wr;
  logic [1:0]         reg_sel;
  logic               q_full, q_empty, q_push, q_pop;

  // Register file
  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orders_q.ord_i <= hohni_pkg::OrdW'(1);
      orders_q.ord_j <= hohni_pkg::OrdW'(1);
      orders_q.ord_k <= hohni_pkg::OrdW'(1);
    end else if (cfg_wr) begin
      case (reg_sel)
        hohni_pkg::RegOrderI: orders_q.ord_i <= pwdata[hohni_pkg::OrdW-1:0];
        hohni_pkg::RegOrderJ: orders_q.ord_j <= pwdata[hohni_pkg::OrdW-1:0];
        hohni_pkg::RegOrderK: orders_q.ord_k <= pwdata[hohni_pkg::OrdW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      hohni_pkg::RegOrderI: prdata = hohni_pkg::DataW'(orders_q.ord_i);
      hohni_pkg::RegOrderJ: prdata = hohni_pkg::DataW'(orders_q.ord_j);
      hohni_pkg::RegOrderK: prdata = hohni_pkg::DataW'(orders_q.ord_k);
      default:              prdata = '0;
    endcase
  end

  // Classify
  hohni_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .orders_i  (orders_q),
    .coord_i_i (coord_i_i),
    .coord_j_i (coord_j_i),
    .coord_k_i (coord_k_i),
    .entry_o   (front_entry)
  );

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  hohni_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (front_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (queue_entry)
  );

  // Compute and present the index
  hohni_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .entry_i        (queue_entry),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .node_index_o   (node_index_o),
    .node_class_o   (node_class_o),
    .out_of_range_o (out_of_range_o)
  );

  // An out-of-range result carries index and class zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (node_index_o == '0 && node_class_o == '0))
    else $error("out-of-range result with nonzero index or class");

  // A vertex always lands among the eight corners
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_of_range_o && node_class_o == hohni_pkg::ClsVertex)
      |-> (node_index_o < hohni_pkg::CornerCount))
    else $error("vertex index beyond corner range");

  // A full queue must hold the input side off until a slot frees
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_full && !q_pop) |=> q_full)
    else $error("queue lost an entry without a pop");

endmodule
